[design/pfrs_pkg.sv]
// Shared types, opcodes and register indexes for the PWM fade ramp scheduler.
package pfrs_pkg;

    localparam int LEVEL_BITS    = 12;
    localparam int TIME_BITS     = 24;
    localparam int PERIOD_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = TIME_BITS;

    typedef logic [LEVEL_BITS-1:0]  level_t;
    typedef logic [TIME_BITS-1:0]   tval_t;
    typedef logic [PERIOD_BITS-1:0] period_t;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_SET        = 3'd1,
        OP_FADE_SPEED = 3'd2,
        OP_FADE_TIME  = 3'd3,
        OP_SET_LATER  = 3'd4,
        OP_FADE_LATER = 3'd5,
        OP_STOP       = 3'd6
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_ON_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFF_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_PERIOD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_AUTO_FADE   = 3'd4;

    localparam level_t  ON_LEVEL_RST    = 12'd4095;
    localparam level_t  OFF_LEVEL_RST   = 12'd0;
    localparam level_t  INIT_LEVEL_RST  = 12'd0;
    localparam period_t STEP_PERIOD_RST = 16'd20;
    localparam tval_t   AUTO_FADE_RST   = 24'd1000;

    typedef struct packed {
        logic [2:0] opcode;
        level_t     target_level;
        level_t     step_size;
        tval_t      fade_ms;
        level_t     future_level;
        tval_t      delay_ms;
    } cmd_t;

    typedef struct packed {
        level_t drive_level;
        logic   drive_updated;
        logic   reached;
        logic   is_fading;
        logic   is_waiting;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic div_start;
        logic div_sel;      // 0: duration / period, 1: distance / steps
        logic fade_commit;
        logic do_step;
        logic do_drive;
        logic load_out;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic dur_fade;
        logic fire_fade;
        logic fade_same;
        logic div_done;
    } status_t;

endpackage

[design/pfrs_div.sv]
// Restoring divider, one quotient bit per cycle.
module pfrs_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pfrs_pkg::tval_t        dividend,
    input  pfrs_pkg::tval_t        divisor,
    output pfrs_pkg::tval_t        quotient,
    output logic                   done
);
    import pfrs_pkg::*;

    localparam int W        = TIME_BITS;
    localparam int CNT_BITS = $clog2(W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    tval_t               rem_reg, rem_next;
    tval_t               quo_reg, quo_next;
    tval_t               dvs_reg, dvs_next;
    logic [W:0]          shifted;
    logic [W:0]          diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[design/pfrs_datapath.sv]
// Datapath: configuration, fade/wait state, step arithmetic, divider, result register.
module pfrs_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pfrs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pfrs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  pfrs_pkg::cmd_t                        cmd,
    input  pfrs_pkg::ctrl_t                       ctl,
    output pfrs_pkg::status_t                     sts,
    output pfrs_pkg::res_t                        res
);
    import pfrs_pkg::*;

    // configuration
    level_t  on_reg;
    level_t  off_reg;
    period_t period_reg;
    tval_t   auto_reg;

    // item and fade operands
    cmd_t    cmd_reg;
    level_t  aim_op_reg, aim_op_next;
    tval_t   dur_op_reg, dur_op_next;
    res_t    res_reg;

    // block state
    level_t  cur_reg, cur_next;
    level_t  drv_reg, drv_next;
    level_t  aim_reg, aim_next;
    level_t  fstep_reg, fstep_next;
    logic    fading_reg, fading_next;
    period_t selap_reg, selap_next;
    logic    waiting_reg, waiting_next;
    tval_t   welap_reg, welap_next;
    tval_t   wlimit_reg, wlimit_next;
    level_t  plevel_reg, plevel_next;
    logic    pfades_reg, pfades_next;
    logic    fresh_reg, fresh_next;
    logic    upd_reg, upd_next;
    logic    rch_reg, rch_next;

    tval_t   welap_inc;
    logic    wait_fire;
    period_t selap_inc;
    logic    step_due;
    level_t  hi_lvl, lo_lvl;
    logic [LEVEL_BITS:0] cur_up, aim_up;
    level_t  stepped, clamped;
    level_t  fade_dist;
    tval_t   period_ext;
    tval_t   quotient;
    tval_t   div_dividend, div_divisor, q_floor;
    logic    div_done;
    logic    is_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg     <= ON_LEVEL_RST;
            off_reg    <= OFF_LEVEL_RST;
            period_reg <= STEP_PERIOD_RST;
            auto_reg   <= AUTO_FADE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ON_LEVEL:    on_reg     <= cfg_data[LEVEL_BITS-1:0];
                REG_OFF_LEVEL:   off_reg    <= cfg_data[LEVEL_BITS-1:0];
                // init level only matters at reset, and reset restores its default
                REG_INIT_LEVEL:  ;
                REG_STEP_PERIOD: period_reg <= cfg_data[PERIOD_BITS-1:0];
                REG_AUTO_FADE:   auto_reg   <= cfg_data[TIME_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign is_tick   = (cmd_reg.opcode == OP_TICK);
    assign welap_inc = (welap_reg == '1) ? welap_reg : welap_reg + 1'b1;
    assign wait_fire = waiting_reg && (welap_inc > wlimit_reg);
    assign selap_inc = (selap_reg == '1) ? selap_reg : selap_reg + 1'b1;
    assign step_due  = selap_inc > period_reg;

    // one fade step toward the aim, then clamp between on and off levels
    assign hi_lvl = (on_reg > off_reg) ? on_reg : off_reg;
    assign lo_lvl = (on_reg > off_reg) ? off_reg : on_reg;
    assign cur_up = {1'b0, cur_reg} + {1'b0, fstep_reg};
    assign aim_up = {1'b0, aim_reg} + {1'b0, fstep_reg};

    always_comb
    begin
        if (cur_reg > aim_reg)
            stepped = ({1'b0, cur_reg} > aim_up) ? cur_reg - fstep_reg : aim_reg;
        else
            stepped = (cur_up > {1'b0, aim_reg}) ? aim_reg : cur_up[LEVEL_BITS-1:0];
        if (stepped > hi_lvl)
            clamped = hi_lvl;
        else if (stepped < lo_lvl)
            clamped = lo_lvl;
        else
            clamped = stepped;
    end

    // divider operands
    assign fade_dist    = (aim_op_reg > cur_reg) ? aim_op_reg - cur_reg : cur_reg - aim_op_reg;
    assign period_ext   = (period_reg == '0) ? TIME_BITS'(1) : TIME_BITS'(period_reg);
    assign q_floor      = (quotient == '0) ? TIME_BITS'(1) : quotient;
    assign div_dividend = ctl.div_sel ? TIME_BITS'(fade_dist) : dur_op_reg;
    assign div_divisor  = ctl.div_sel ? q_floor : period_ext;

    pfrs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        aim_op_next  = aim_op_reg;
        dur_op_next  = dur_op_reg;
        cur_next     = cur_reg;
        drv_next     = drv_reg;
        aim_next     = aim_reg;
        fstep_next   = fstep_reg;
        fading_next  = fading_reg;
        selap_next   = selap_reg;
        waiting_next = waiting_reg;
        welap_next   = welap_reg;
        wlimit_next  = wlimit_reg;
        plevel_next  = plevel_reg;
        pfades_next  = pfades_reg;
        fresh_next   = fresh_reg;
        upd_next     = upd_reg;
        rch_next     = rch_reg;

        if (ctl.load_in)
        begin
            upd_next   = 1'b0;
            rch_next   = 1'b0;
            fresh_next = 1'b0;
        end

        if (ctl.exec && is_tick)
        begin
            aim_op_next = plevel_reg;
            dur_op_next = auto_reg;
            if (waiting_reg)
            begin
                welap_next = welap_inc;
                if (wait_fire)
                begin
                    waiting_next = 1'b0;
                    fading_next  = 1'b0;
                    if (!pfades_reg)
                        cur_next = plevel_reg;
                end
            end
        end
        else if (ctl.exec)
        begin
            aim_op_next = cmd_reg.target_level;
            dur_op_next = cmd_reg.fade_ms;
            unique case (cmd_reg.opcode)
                OP_SET:
                begin
                    cur_next    = cmd_reg.target_level;
                    fading_next = 1'b0;
                end
                OP_FADE_SPEED:
                begin
                    if (cur_reg != cmd_reg.target_level)
                    begin
                        fstep_next  = cmd_reg.step_size;
                        aim_next    = cmd_reg.target_level;
                        fading_next = 1'b1;
                        selap_next  = '0;
                    end
                end
                OP_SET_LATER, OP_FADE_LATER:
                begin
                    waiting_next = 1'b1;
                    wlimit_next  = cmd_reg.delay_ms;
                    welap_next   = '0;
                    plevel_next  = cmd_reg.future_level;
                    pfades_next  = (cmd_reg.opcode == OP_FADE_LATER);
                    if (cmd_reg.opcode == OP_SET_LATER)
                    begin
                        cur_next    = cmd_reg.target_level;
                        fading_next = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    waiting_next = 1'b0;
                    fading_next  = 1'b0;
                end
                default: ;
            endcase
        end

        if (ctl.fade_commit)
        begin
            fstep_next  = q_floor[LEVEL_BITS-1:0];
            aim_next    = aim_op_reg;
            fading_next = 1'b1;
            selap_next  = '0;
            fresh_next  = 1'b1;
        end

        // a fade started on this tick takes no step yet
        if (ctl.do_step && fading_reg && !fresh_reg)
        begin
            selap_next = step_due ? '0 : selap_inc;
            if (step_due)
                cur_next = clamped;
        end

        if (ctl.do_drive && (drv_reg != cur_reg))
        begin
            drv_next = cur_reg;
            upd_next = 1'b1;
            if (cur_reg == on_reg || cur_reg == off_reg || cur_reg == aim_reg)
            begin
                fading_next = 1'b0;
                rch_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= INIT_LEVEL_RST;
            drv_reg     <= '0;
            aim_reg     <= '0;
            fstep_reg   <= '0;
            fading_reg  <= 1'b0;
            selap_reg   <= '0;
            waiting_reg <= 1'b0;
            welap_reg   <= '0;
            wlimit_reg  <= '0;
            plevel_reg  <= '0;
            pfades_reg  <= 1'b0;
            fresh_reg   <= 1'b0;
            upd_reg     <= 1'b0;
            rch_reg     <= 1'b0;
        end
        else
        begin
            cur_reg     <= cur_next;
            drv_reg     <= drv_next;
            aim_reg     <= aim_next;
            fstep_reg   <= fstep_next;
            fading_reg  <= fading_next;
            selap_reg   <= selap_next;
            waiting_reg <= waiting_next;
            welap_reg   <= welap_next;
            wlimit_reg  <= wlimit_next;
            plevel_reg  <= plevel_next;
            pfades_reg  <= pfades_next;
            fresh_reg   <= fresh_next;
            upd_reg     <= upd_next;
            rch_reg     <= rch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aim_op_reg <= aim_op_next;
        dur_op_reg <= dur_op_next;
        if (ctl.load_in)
            cmd_reg <= cmd;
        if (ctl.load_out)
            res_reg <= '{drive_level:   drv_reg,
                         drive_updated: upd_reg,
                         reached:       rch_reg,
                         is_fading:     fading_reg,
                         is_waiting:    waiting_reg};
    end

    assign sts.is_tick   = is_tick;
    assign sts.dur_fade  = (cmd_reg.opcode == OP_FADE_TIME) || (cmd_reg.opcode == OP_FADE_LATER);
    assign sts.fire_fade = wait_fire && pfades_reg;
    assign sts.fade_same = (cur_reg == aim_op_reg);
    assign sts.div_done  = div_done;
    assign res           = res_reg;

endmodule

[design/pfrs_ctrl.sv]
// Controller: sequences each item through the datapath and owns the handshakes.
module pfrs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  pfrs_pkg::status_t    sts,
    output pfrs_pkg::ctrl_t      ctl
);
    import pfrs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_FADE_CHK = 8'b0000_0100,
        S_DIV1     = 8'b0000_1000,
        S_DIV2     = 8'b0001_0000,
        S_STEP     = 8'b0010_0000,
        S_DRIVE    = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_free  = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ctl            = '0;
        ctl.load_in    = cmd_valid && cmd_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.is_tick)
                    state_next = sts.fire_fade ? S_FADE_CHK : S_STEP;
                else
                    state_next = sts.dur_fade ? S_FADE_CHK : S_RESULT;
            end
            S_FADE_CHK:
            begin
                // aim already equals the level: no fade
                if (sts.fade_same)
                    state_next = sts.is_tick ? S_STEP : S_RESULT;
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = 1'b1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (sts.div_done)
                begin
                    ctl.fade_commit = 1'b1;
                    state_next      = sts.is_tick ? S_STEP : S_RESULT;
                end
            end
            S_STEP:
            begin
                ctl.do_step = 1'b1;
                state_next  = S_DRIVE;
            end
            S_DRIVE:
            begin
                ctl.do_drive = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    ctl.load_out   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

[design/pwm_fade_ramp_scheduler.sv]
// Top level of the PWM fade ramp scheduler: controller plus datapath.
// Sequence: a command goes exec then result; a tick exec, step, drive, result.
// A duration fade (command, or a fading change that fires on a tick) adds two
// passes of the shared bit-serial divider. Throughput: one item at a time; the
// next transfer is taken once the result sits in the output register. Reset:
// asynchronous, active low, state levels, flags and counters cleared,
// configuration back to its defaults.
module pwm_fade_ramp_scheduler
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pfrs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pfrs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  pfrs_pkg::cmd_t                        cmd,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output pfrs_pkg::res_t                        res
);
    import pfrs_pkg::*;

    ctrl_t   ctl;
    status_t sts;

    pfrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    pfrs_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res)
    );

endmodule

[design/pfrs_checker.sv]
// Port-level assertions for the PWM fade ramp scheduler, bound to the top level.
module pfrs_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic              res_valid,
    input  logic              res_ready,
    input  pfrs_pkg::res_t    res
);
    import pfrs_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // one item in flight: no transfer in the cycle right after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("input ready right after a transfer");

    // completion only comes with a level change and ends the fade
    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.reached |-> res.drive_updated && !res.is_fading)
        else $error("reached without update or with fade still running");

    // a new result shows up only after an input transfer has been taken
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !cmd_ready || $past(!cmd_ready))
        else $error("result without a preceding transfer");

endmodule

bind pwm_fade_ramp_scheduler pfrs_checker u_pfrs_checker (.*);
